// ===== hw/rtl/filled_circle_raster_painter_assert.svh =====
// Assertion macros for the filled circle raster painter.
`ifndef FILLED_CIRCLE_RASTER_PAINTER_ASSERT_SVH
`define FILLED_CIRCLE_RASTER_PAINTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/fcr_pkg.sv =====
// Shared types and constants of the filled circle raster painter.
package fcr_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int POS_W    = 6;
    localparam int COORD_W  = 7;
    localparam int RADIUS_W = 7;
    localparam int COLOUR_W = 4;
    localparam int GRID_W   = 7;
    localparam int GRID_MAX = (1 << GRID_W) - 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } ctl_state_t;

    // Clipped bounding box and disc parameters of one draw.
    typedef struct packed {
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  x1;
        logic [COORD_W-1:0]  y0;
        logic [COORD_W-1:0]  y1;
        logic [POS_W-1:0]    cx;
        logic [POS_W-1:0]    cy;
        logic [RADIUS_W-1:0] radius;
        logic [COLOUR_W-1:0] colour;
    } scan_cmd_t;

endpackage

// ===== hw/rtl/fcr_disc_scan.sv =====
// Bounding box scanner: one pixel per cycle, disc test, frame store write.
module fcr_disc_scan #(
    parameter int MAX_WIDTH = fcr_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W    = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  fcr_pkg::scan_cmd_t            cmd,
    output logic                          scan_busy,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output logic [fcr_pkg::COLOUR_W-1:0]  wr_data
);

    fcr_pkg::scan_cmd_t             cmd_reg;
    logic [fcr_pkg::SQ_W-1:0]       r2_reg;
    logic [fcr_pkg::COORD_W-1:0]    sx_reg, sx_next;
    logic [fcr_pkg::COORD_W-1:0]    sy_reg, sy_next;
    logic                           run_reg, run_next;

    // pipeline stage 1
    logic                           s1_vld_reg;
    logic [fcr_pkg::SQ_W-1:0]       dx2_reg, dy2_reg;
    logic [ADDR_W-1:0]              s1_addr_reg;

    logic [fcr_pkg::COORD_W-1:0]    cx7, cy7, dx, dy;
    logic [fcr_pkg::SQ_W:0]         dist2;

    assign cx7 = {1'b0, cmd_reg.cx};
    assign cy7 = {1'b0, cmd_reg.cy};
    assign dx  = (sx_reg >= cx7) ? (sx_reg - cx7) : (cx7 - sx_reg);
    assign dy  = (sy_reg >= cy7) ? (sy_reg - cy7) : (cy7 - sy_reg);

    always_comb
    begin
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        run_next = run_reg;
        if (go)
        begin
            sx_next  = cmd.x0;
            sy_next  = cmd.y0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (sx_reg == cmd_reg.x1)
            begin
                sx_next = cmd_reg.x0;
                if (sy_reg == cmd_reg.y1)
                begin
                    run_next = 1'b0;
                end
                else
                begin
                    sy_next = sy_reg + 1'b1;
                end
            end
            else
            begin
                sx_next = sx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            run_reg    <= run_next;
            s1_vld_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            cmd_reg <= cmd;
            r2_reg  <= fcr_pkg::SQ_W'(cmd.radius) * fcr_pkg::SQ_W'(cmd.radius);
        end
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        dx2_reg     <= fcr_pkg::SQ_W'(dx) * fcr_pkg::SQ_W'(dx);
        dy2_reg     <= fcr_pkg::SQ_W'(dy) * fcr_pkg::SQ_W'(dy);
        s1_addr_reg <= ADDR_W'(sy_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_reg);
    end

    // stage 2: inside test and write
    assign dist2     = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign wr_en     = s1_vld_reg && (dist2 <= {1'b0, r2_reg});
    assign wr_addr   = s1_addr_reg;
    assign wr_data   = cmd_reg.colour;
    assign scan_busy = run_reg || s1_vld_reg;

endmodule

// ===== hw/rtl/filled_circle_raster_painter.sv =====
// Filled circle raster painter: frame store, control and configuration.
//
// Usage:
//   Items: an item transfers at a rising edge with start high and busy low.
//   kind = draw paints the disc of radius around (pos_x, pos_y) in colour,
//   clipped to the configured grid; a centre outside the grid paints nothing.
//   kind = read returns the stored colour of pixel (pos_x, pos_y), or 0 if
//   the pixel lies outside the grid.
//   Results: done is high for exactly one cycle, the cycle after the read
//   transfer, with pixel_colour valid in that cycle. The receiver cannot
//   stall; a result is taken in the cycle it is shown. Draws give no result.
//   Busy: a read holds busy through its result cycle, so the next item
//   can transfer only after the result is shown. A draw holds busy while
//   the clipped bounding box is scanned at one pixel per cycle through a
//   two-stage square and compare pipeline into the single frame store
//   write port. A draw whose centre is off the grid paints nothing and
//   leaves busy low.
//   Configuration: cfg_valid/cfg_ready write grid_width (index 0) or
//   grid_height (index 1); cfg_ready is always high. Write only when idle.
//   Reset: grid is 64 by 64; busy stays high while the whole frame store
//   is cleared to colour 0.
module filled_circle_raster_painter #(
    parameter int MAX_WIDTH  = fcr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fcr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [fcr_pkg::POS_W-1:0]       pos_x,
    input  logic [fcr_pkg::POS_W-1:0]       pos_y,
    input  logic [fcr_pkg::RADIUS_W-1:0]    radius,
    input  logic [fcr_pkg::COLOUR_W-1:0]    colour,
    // result channel
    output logic                            done,
    output logic [fcr_pkg::COLOUR_W-1:0]    pixel_colour,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcr_pkg::GRID_W-1:0]      cfg_data
);

    `include "filled_circle_raster_painter_assert.svh"

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // grid limits seen through the 7-bit registers
    localparam int W_LIM  = (MAX_WIDTH  > fcr_pkg::GRID_MAX) ? fcr_pkg::GRID_MAX : MAX_WIDTH;
    localparam int H_LIM  = (MAX_HEIGHT > fcr_pkg::GRID_MAX) ? fcr_pkg::GRID_MAX : MAX_HEIGHT;

    fcr_pkg::ctl_state_t state_reg, state_next;

    logic [fcr_pkg::GRID_W-1:0]    grid_width_reg, grid_height_reg;
    logic [fcr_pkg::GRID_W-1:0]    eff_w, eff_h;
    logic [ADDR_W-1:0]             clr_addr_reg, clr_addr_next;

    // frame store: one write port, one registered read port
    logic [fcr_pkg::COLOUR_W-1:0]  frame_mem [DEPTH];
    logic [fcr_pkg::COLOUR_W-1:0]  mem_q_reg;
    logic                          rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]             pos_addr;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [fcr_pkg::COLOUR_W-1:0]  mem_wdata;

    logic                          accept, in_grid, go;
    logic                          rd_accept, in_scan, in_clear;
    fcr_pkg::scan_cmd_t            cmd;
    logic [fcr_pkg::COORD_W-1:0]   cx7, cy7;
    logic [fcr_pkg::COORD_W:0]     xs8, ys8;

    logic                          scan_busy, scan_wr_en;
    logic [ADDR_W-1:0]             scan_wr_addr;
    logic [fcr_pkg::COLOUR_W-1:0]  scan_wr_data;

    // effective grid, saturated at the store size
    assign eff_w = (grid_width_reg  > fcr_pkg::GRID_W'(W_LIM)) ?
                   fcr_pkg::GRID_W'(W_LIM) : grid_width_reg;
    assign eff_h = (grid_height_reg > fcr_pkg::GRID_W'(H_LIM)) ?
                   fcr_pkg::GRID_W'(H_LIM) : grid_height_reg;

    assign cx7     = {1'b0, pos_x};
    assign cy7     = {1'b0, pos_y};
    assign in_grid = (cx7 < eff_w) && (cy7 < eff_h);
    assign accept  = start && !busy;
    assign rd_accept = accept && (kind == fcr_pkg::KIND_READ);
    assign in_scan   = (state_reg == fcr_pkg::ST_SCAN);
    assign in_clear  = (state_reg == fcr_pkg::ST_CLEAR);
    assign pos_addr = ADDR_W'(pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pos_x);

    // clipped bounding box; only used when the centre is on the grid
    assign xs8 = {2'b0, pos_x} + {1'b0, radius};
    assign ys8 = {2'b0, pos_y} + {1'b0, radius};

    always_comb
    begin
        cmd.x0     = (cx7 > radius) ? (cx7 - radius) : '0;
        cmd.y0     = (cy7 > radius) ? (cy7 - radius) : '0;
        cmd.x1     = (xs8 < {1'b0, eff_w}) ? xs8[fcr_pkg::COORD_W-1:0] : (eff_w - 1'b1);
        cmd.y1     = (ys8 < {1'b0, eff_h}) ? ys8[fcr_pkg::COORD_W-1:0] : (eff_h - 1'b1);
        cmd.cx     = pos_x;
        cmd.cy     = pos_y;
        cmd.radius = radius;
        cmd.colour = colour;
    end

    // control FSM
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        rd_ok_next    = rd_ok_reg;
        busy          = 1'b1;
        done          = 1'b0;
        go            = 1'b0;
        case (state_reg)
            fcr_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = fcr_pkg::ST_IDLE;
                end
            end
            fcr_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (kind == fcr_pkg::KIND_READ)
                    begin
                        rd_ok_next = in_grid;
                        state_next = fcr_pkg::ST_RESP;
                    end
                    else if (in_grid)
                    begin
                        go         = 1'b1;
                        state_next = fcr_pkg::ST_SCAN;
                    end
                end
            end
            fcr_pkg::ST_SCAN:
            begin
                if (!scan_busy)
                begin
                    state_next = fcr_pkg::ST_IDLE;
                end
            end
            fcr_pkg::ST_RESP:
            begin
                done       = 1'b1;
                state_next = fcr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fcr_pkg::ST_CLEAR;
            clr_addr_reg    <= '0;
            rd_ok_reg       <= 1'b0;
            grid_width_reg  <= fcr_pkg::GRID_RESET;
            grid_height_reg <= fcr_pkg::GRID_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_ok_reg    <= rd_ok_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fcr_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    fcr_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;

    // write port: clearing sweep after reset, scanner otherwise
    assign mem_we    = in_clear || scan_wr_en;
    assign mem_waddr = in_clear ? clr_addr_reg : scan_wr_addr;
    assign mem_wdata = in_clear ? '0 : scan_wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= frame_mem[pos_addr];
    end

    // off-grid reads return colour 0
    assign pixel_colour = rd_ok_reg ? mem_q_reg : '0;

    fcr_disc_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cmd       (cmd),
        .scan_busy (scan_busy),
        .wr_en     (scan_wr_en),
        .wr_addr   (scan_wr_addr),
        .wr_data   (scan_wr_data)
    );

    `FCR_ASSERT_NEXT(a_read_resp, clk, rst_n, rd_accept, done, "read without next-cycle result")
    `FCR_ASSERT_IMPL(a_scan_wr_in_scan, clk, rst_n, scan_wr_en, in_scan, "write outside draw")
    `FCR_ASSERT_IMPL(a_clear_idle, clk, rst_n, in_clear, !done && !scan_busy, "clear not quiet")
    `FCR_ASSERT_NEXT(a_draw_scan, clk, rst_n, go, scan_busy && busy, "scanner not started")

endmodule
